// ===== sv/tsrm_pkg.sv =====
`timescale 1ns / 1ps
package tsrm_pkg;

  localparam int unsigned TASK_SLOTS_DEF = 16;

  localparam int unsigned IN_DATA_W  = 192;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 480;

  localparam int unsigned DIV_W = 64;
  localparam int unsigned DVS_W = 32;

  localparam logic [31:0] STEP_FLOOR   = 32'd1000;
  localparam logic [29:0] NS_PER_S     = 30'd1000000000;

  typedef enum logic [1:0] {
    OP_REG     = 2'd0,
    OP_SWITCH  = 2'd1,
    OP_RUNTIME = 2'd2,
    OP_READ    = 2'd3
  } tsrm_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SCAN_END,
    S_LOOK,
    S_LOAD,
    S_EXEC,
    S_DL_DIV,
    S_CONS,
    S_MEAN_DIV
  } tsrm_state_e;

  // one classified request as it travels from front to back
  typedef struct packed {
    tsrm_op_e    op;
    logic        slot_ok;
    logic [3:0]  slot;
    logic [21:0] task_id;
    logic [21:0] incoming_id;
    logic [62:0] ts;
    logic [31:0] runtime;
    logic [7:0]  preempt;
    logic [31:0] period;
    logic        dmode;
    logic        active;
  } tsrm_cmd_t;

  // per-slot record kept in the table memory
  typedef struct packed {
    logic               active;
    logic               dmode;
    logic [31:0]        period;
    logic [62:0]        deadline;
    logic [39:0]        acc;
    logic signed [63:0] slack_low;
    logic signed [63:0] slack_high;
    logic [39:0]        run_low;
    logic [39:0]        run_high;
    logic [39:0]        run_mean;
    logic [31:0]        events;
    logic [31:0]        preempts;
  } tsrm_entry_t;

  // result word, laid out as it appears on the output bus (lowest field last)
  typedef struct packed {
    logic [31:0]        preempt_sum;
    logic [31:0]        event_count;
    logic [62:0]        next_deadline;
    logic [39:0]        runtime_avg;
    logic [39:0]        runtime_max;
    logic [39:0]        runtime_min;
    logic signed [63:0] slack_max;
    logic signed [63:0] slack_min;
    logic signed [63:0] slack;
    logic [39:0]        last_runtime;
    logic               found;
  } tsrm_res_t;

  function automatic tsrm_res_t tsrm_show(tsrm_entry_t e, logic [39:0] acc,
                                          logic signed [63:0] slack);
    tsrm_res_t r;
    r.found         = 1'b1;
    r.last_runtime  = acc;
    r.slack         = slack;
    r.slack_min     = e.slack_low;
    r.slack_max     = e.slack_high;
    r.runtime_min   = e.run_low;
    r.runtime_max   = e.run_high;
    r.runtime_avg   = e.run_mean;
    r.next_deadline = e.deadline;
    r.event_count   = e.events;
    r.preempt_sum   = e.preempts;
    return r;
  endfunction

endpackage

// ===== sv/task_switch_runtime_monitor_core.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake                      tdata / tuser
// s_axis    in   s_axis_tvalid / s_axis_tready  request fields / opcode
// m_axis    out  m_axis_tvalid / m_axis_tready  one result per request
//
// request handling time is set by the slot-by-slot id search for runtime events and
// switches, the bit-serial deadline divider when a switch must catch a deadline up,
// and the shift-add divide by ten of the mean on a switch; while a result waits for
// ready, no further request enters the back end.
// reset clears slot valid bits and control; table memories are not cleared.
// a two-entry request queue keeps accepting while a result waits for ready.
module task_switch_runtime_monitor_core #(
  parameter int unsigned TASK_SLOTS = tsrm_pkg::TASK_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // slot[3:0], task_id[25:4], incoming_id[47:26], timestamp_ns[110:48],
  // runtime_ns[142:111], preempt_count[150:143], period_ns[182:151],
  // deadline_mode[183], active[184], zero fill
  input  logic [tsrm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // opcode[1:0]
  input  logic [tsrm_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // found[0], last_runtime[40:1], slack[104:41], slack_min[168:105],
  // slack_max[232:169], runtime_min[272:233], runtime_max[312:273],
  // runtime_avg[352:313], next_deadline[415:353], event_count[447:416],
  // preempt_sum[479:448]
  output logic [tsrm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import tsrm_pkg::*;

  tsrm_cmd_t cmd;
  logic      cmd_valid, cmd_ready;

  tsrm_front #(.TASK_SLOTS(TASK_SLOTS)) u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  tsrm_back #(.TASK_SLOTS(TASK_SLOTS)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

endmodule

// ===== sv/tsrm_ram.sv =====
`timescale 1ns / 1ps
module tsrm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/tsrm_div.sv =====
`timescale 1ns / 1ps
module tsrm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tsrm_pkg::DIV_W-1:0] dividend_i,
  input  logic [tsrm_pkg::DVS_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [tsrm_pkg::DVS_W-1:0] remainder_o
);
  import tsrm_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [DVS_W:0]   rem_sub;

  // one restoring step: shift in next dividend bit, subtract if it fits
  assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      cnt_q <= CNT_W'(DIV_W - 1);
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= rem_sub[DVS_W-1:0];
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign remainder_o = rem_q;

endmodule

// ===== sv/tsrm_front.sv =====
`timescale 1ns / 1ps
module tsrm_front #(
  parameter int unsigned TASK_SLOTS = tsrm_pkg::TASK_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tsrm_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic [tsrm_pkg::IN_USER_W-1:0] s_axis_tuser,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output tsrm_pkg::tsrm_cmd_t           cmd_o
);
  import tsrm_pkg::*;

  tsrm_cmd_t  cmd_in;
  tsrm_cmd_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  // unpack and classify the incoming request
  always_comb begin
    cmd_in.op          = tsrm_op_e'(s_axis_tuser);
    cmd_in.slot        = s_axis_tdata[3:0];
    cmd_in.slot_ok     = 32'(s_axis_tdata[3:0]) < TASK_SLOTS;
    cmd_in.task_id     = s_axis_tdata[25:4];
    cmd_in.incoming_id = s_axis_tdata[47:26];
    cmd_in.ts          = s_axis_tdata[110:48];
    cmd_in.runtime     = s_axis_tdata[142:111];
    cmd_in.preempt     = s_axis_tdata[150:143];
    cmd_in.period      = s_axis_tdata[182:151];
    cmd_in.dmode       = s_axis_tdata[183];
    cmd_in.active      = s_axis_tdata[184];
  end

  assign s_axis_tready = cnt_q != 2'd2;
  assign cmd_valid_o   = cnt_q != 2'd0;
  assign cmd_o         = mem_q[rd_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = cmd_valid_o && cmd_ready_i;

  // two-entry queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_in;
    end
  end

endmodule

// ===== sv/tsrm_back.sv =====
`timescale 1ns / 1ps
module tsrm_back #(
  parameter int unsigned TASK_SLOTS = tsrm_pkg::TASK_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  input  tsrm_pkg::tsrm_cmd_t            cmd_i,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [tsrm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import tsrm_pkg::*;

  localparam int unsigned IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned ENT_W = $bits(tsrm_entry_t);

  tsrm_state_e state_q, state_d;
  tsrm_cmd_t   cmd_q;
  logic [TASK_SLOTS-1:0] valid_q;
  logic [IDX_W-1:0] scan_q, cmp_idx_q, s_out_q, s_in_q, slot_idx;
  logic        cmp_vld_q, hit_out_q, hit_in_q, match_out, match_in;
  tsrm_entry_t ent_q, ent_fresh, ent_rt, ent_sw;
  logic [62:0] last_q;
  logic [39:0] acc_q, acc_sw;
  logic [31:0] step_q, step_c;
  logic signed [63:0] slack_q, slack_c;
  tsrm_res_t   res_q, res_d;
  logic        out_vld_q, res_ld;

  // memory ports
  logic             id_we, dat_we, lst_we;
  logic [IDX_W-1:0] id_waddr, dat_waddr, lst_waddr, dat_raddr;
  logic [21:0]      id_rdata;
  tsrm_entry_t      dat_wdata;
  logic [ENT_W-1:0] dat_rdata;
  logic [62:0]      lst_wdata, lst_rdata;

  // divider
  logic             div_start, div_busy, div_done;
  logic [DIV_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs, div_rem;

  // arithmetic helpers
  logic [63:0] el_diff, dl_sum;
  logic [29:0] el;
  logic [40:0] acc_sum, acc_rt_sum;
  logic [32:0] pre_sum, ev_sum;
  logic        need_adv;
  logic [31:0] dl_off;
  logic [62:0] dl_new;
  logic [44:0] mean9;

  // divide by ten for the moving average
  logic [63:0] mn_q, mq_q, mq_sh, mq_rem;
  logic [2:0]  mstep_q;
  logic        mean_done;

  assign slot_idx = IDX_W'(cmd_q.slot);

  tsrm_ram #(.WIDTH(22), .DEPTH(TASK_SLOTS)) u_id_ram (
    .clk_i, .we_i(id_we), .waddr_i(id_waddr), .wdata_i(cmd_q.task_id),
    .raddr_i(scan_q), .rdata_o(id_rdata)
  );

  tsrm_ram #(.WIDTH(ENT_W), .DEPTH(TASK_SLOTS)) u_dat_ram (
    .clk_i, .we_i(dat_we), .waddr_i(dat_waddr), .wdata_i(dat_wdata),
    .raddr_i(dat_raddr), .rdata_o(dat_rdata)
  );

  tsrm_ram #(.WIDTH(63), .DEPTH(TASK_SLOTS)) u_lst_ram (
    .clk_i, .we_i(lst_we), .waddr_i(lst_waddr), .wdata_i(lst_wdata),
    .raddr_i(dat_raddr), .rdata_o(lst_rdata)
  );

  tsrm_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dvd), .divisor_i(div_dvs),
    .busy_o(div_busy), .done_o(div_done), .remainder_o(div_rem)
  );

  // id search compare, each slot checked in the cycle after its read address is set
  assign match_out = cmp_vld_q && valid_q[cmp_idx_q] && !hit_out_q
                     && id_rdata == cmd_q.task_id;
  assign match_in  = cmp_vld_q && valid_q[cmp_idx_q] && !hit_in_q
                     && id_rdata == cmd_q.incoming_id;

  // fresh record on register
  always_comb begin
    ent_fresh            = '0;
    ent_fresh.active     = cmd_q.active;
    ent_fresh.dmode      = cmd_q.dmode;
    ent_fresh.period     = cmd_q.period;
    ent_fresh.deadline   = cmd_q.ts;
    ent_fresh.slack_low  = {1'b0, {63{1'b1}}};
    ent_fresh.slack_high = {1'b1, 63'd0};
    ent_fresh.run_low    = '1;
  end

  // runtime event update
  always_comb begin
    acc_rt_sum = {1'b0, ent_q.acc} + 41'(cmd_q.runtime);
    pre_sum    = {1'b0, ent_q.preempts} + 33'(cmd_q.preempt);
    ev_sum     = {1'b0, ent_q.events} + 33'd1;
    ent_rt     = ent_q;
    if (ent_q.active) begin
      ent_rt.acc      = acc_rt_sum[40] ? '1 : acc_rt_sum[39:0];
      ent_rt.preempts = pre_sum[32] ? '1 : pre_sum[31:0];
      ent_rt.events   = ev_sum[32] ? '1 : ev_sum[31:0];
    end
  end

  // elapsed time of the outgoing task, clamped, added to its accumulator
  always_comb begin
    el_diff = {1'b0, cmd_q.ts} - {1'b0, last_q};
    if (el_diff[63] || el_diff[62:0] > 63'(NS_PER_S)) begin
      el = NS_PER_S;
    end else if (el_diff[62:0] == '0) begin
      el = 30'd1;
    end else begin
      el = el_diff[29:0];
    end
    acc_sum  = {1'b0, ent_q.acc} + 41'(el);
    acc_sw   = acc_sum[40] ? '1 : acc_sum[39:0];
    need_adv = ent_q.dmode && (ent_q.deadline < cmd_q.ts);
    step_c   = (ent_q.period > STEP_FLOOR) ? ent_q.period : STEP_FLOOR;
  end

  // deadline catch-up from the remainder: next multiple not below ts
  always_comb begin
    dl_off = step_q - div_rem;
    dl_sum = (div_rem == '0) ? {1'b0, cmd_q.ts} : ({1'b0, cmd_q.ts} + 64'(dl_off));
    dl_new = dl_sum[63] ? '1 : dl_sum[62:0];
  end

  // slack and moving-average numerator
  assign slack_c = $signed({1'b0, ent_q.deadline}) - $signed({24'd0, acc_q});
  assign mean9   = {2'b0, ent_q.run_mean, 3'b0} + 45'(ent_q.run_mean) + 45'(acc_q);

  // shift-add reciprocal of ten, last step corrects the quotient by one
  assign mq_sh     = mq_q >> 3;
  assign mq_rem    = mn_q - {mq_sh[60:0], 3'b0} - {mq_sh[62:0], 1'b0};
  assign mean_done = (state_q == S_MEAN_DIV) && (mstep_q == 3'd6);

  // consolidated record after a switch
  always_comb begin
    ent_sw            = ent_q;
    ent_sw.acc        = '0;
    ent_sw.slack_low  = (slack_q < ent_q.slack_low) ? slack_q : ent_q.slack_low;
    ent_sw.slack_high = (slack_q > ent_q.slack_high) ? slack_q : ent_q.slack_high;
    ent_sw.run_low    = (acc_q < ent_q.run_low) ? acc_q : ent_q.run_low;
    ent_sw.run_high   = (acc_q > ent_q.run_high) ? acc_q : ent_q.run_high;
    ent_sw.run_mean   = mq_q[39:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !out_vld_q) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (cmd_q.op)
          OP_REG:  state_d = S_IDLE;
          OP_READ: state_d = (cmd_q.slot_ok && valid_q[slot_idx]) ? S_LOAD : S_IDLE;
          default: state_d = S_SCAN;
        endcase
      end
      S_SCAN: begin
        if (scan_q == IDX_W'(TASK_SLOTS - 1)) state_d = S_SCAN_END;
      end
      S_SCAN_END: state_d = S_LOOK;
      S_LOOK:     state_d = hit_out_q ? S_LOAD : S_IDLE;
      S_LOAD:     state_d = S_EXEC;
      S_EXEC: begin
        if (cmd_q.op == OP_SWITCH) begin
          state_d = need_adv ? S_DL_DIV : S_CONS;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DL_DIV: begin
        if (div_done) state_d = S_CONS;
      end
      S_CONS: state_d = S_MEAN_DIV;
      S_MEAN_DIV: begin
        if (mean_done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs: memory writes, divider start, result load
  always_comb begin
    cmd_ready_o = (state_q == S_IDLE) && !out_vld_q;
    id_we       = 1'b0;
    id_waddr    = slot_idx;
    dat_we      = 1'b0;
    dat_waddr   = s_out_q;
    dat_wdata   = ent_sw;
    dat_raddr   = s_out_q;
    lst_we      = 1'b0;
    lst_waddr   = s_in_q;
    lst_wdata   = cmd_q.ts;
    div_start   = 1'b0;
    div_dvd     = 64'(cmd_q.ts - ent_q.deadline);
    div_dvs     = step_c;
    res_ld      = 1'b0;
    res_d       = '0;
    case (state_q)
      S_DECODE: begin
        dat_raddr = slot_idx;
        case (cmd_q.op)
          OP_REG: begin
            res_ld = 1'b1;
            if (cmd_q.slot_ok) begin
              id_we     = 1'b1;
              dat_we    = 1'b1;
              dat_waddr = slot_idx;
              dat_wdata = ent_fresh;
              lst_we    = 1'b1;
              lst_waddr = slot_idx;
              lst_wdata = '0;
              res_d     = tsrm_show(ent_fresh, '0, '0);
            end
          end
          OP_READ: begin
            res_ld = !(cmd_q.slot_ok && valid_q[slot_idx]);
          end
          default: ;
        endcase
      end
      S_LOOK: begin
        if (!hit_out_q) begin
          res_ld = 1'b1;
          lst_we = (cmd_q.op == OP_SWITCH) && hit_in_q;
        end
      end
      S_EXEC: begin
        case (cmd_q.op)
          OP_READ: begin
            res_ld = 1'b1;
            res_d  = tsrm_show(ent_q, ent_q.acc, '0);
          end
          OP_RUNTIME: begin
            res_ld    = 1'b1;
            res_d     = tsrm_show(ent_rt, ent_rt.acc, '0);
            dat_we    = ent_q.active;
            dat_wdata = ent_rt;
            lst_we    = ent_q.active;
            lst_waddr = s_out_q;
          end
          OP_SWITCH: begin
            div_start = need_adv;
          end
          default: ;
        endcase
      end
      S_MEAN_DIV: begin
        if (mean_done) begin
          res_ld = 1'b1;
          res_d  = tsrm_show(ent_sw, acc_q, slack_q);
          dat_we = 1'b1;
          lst_we = hit_in_q;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      out_vld_q <= 1'b0;
      cmp_vld_q <= 1'b0;
      hit_out_q <= 1'b0;
      hit_in_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= state_q == S_SCAN;
      if (id_we) valid_q[slot_idx] <= 1'b1;
      if (res_ld) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (state_q == S_DECODE) begin
        hit_out_q <= 1'b0;
        hit_in_q  <= 1'b0;
      end else begin
        if (match_out) hit_out_q <= 1'b1;
        if (match_in) hit_in_q <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_ready_o && cmd_valid_i) cmd_q <= cmd_i;
    if (state_q == S_DECODE) begin
      scan_q <= '0;
    end else if (state_q == S_SCAN) begin
      scan_q <= scan_q + 1'b1;
    end
    cmp_idx_q <= scan_q;
    if (match_out) s_out_q <= cmp_idx_q;
    if (match_in) s_in_q <= cmp_idx_q;
    if (state_q == S_LOAD) begin
      ent_q  <= tsrm_entry_t'(dat_rdata);
      last_q <= lst_rdata;
    end
    if (state_q == S_EXEC) begin
      acc_q  <= acc_sw;
      step_q <= step_c;
    end
    if (state_q == S_DL_DIV && div_done) ent_q.deadline <= dl_new;
    if (state_q == S_CONS) slack_q <= slack_c;
    if (res_ld) res_q <= res_d;
  end

  // mean divide steps
  always_ff @(posedge clk_i) begin
    if (state_q == S_CONS) begin
      mn_q    <= 64'(mean9);
      mstep_q <= '0;
    end else if (state_q == S_MEAN_DIV) begin
      mstep_q <= mstep_q + 3'd1;
      case (mstep_q)
        3'd0: mq_q <= {1'b0, mn_q[63:1]} + {2'b0, mn_q[63:2]};
        3'd1: mq_q <= mq_q + {4'b0, mq_q[63:4]};
        3'd2: mq_q <= mq_q + {8'b0, mq_q[63:8]};
        3'd3: mq_q <= mq_q + {16'b0, mq_q[63:16]};
        3'd4: mq_q <= mq_q + {32'b0, mq_q[63:32]};
        3'd5: mq_q <= mq_sh + ((mq_rem > 64'd9) ? 64'd1 : 64'd0);
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q;

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ld |-> !out_vld_q) else $error("result overwritten");

  // the divider is idle whenever a division starts
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  // a found task always sits in a valid slot
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK && hit_out_q) |-> valid_q[s_out_q]) else $error("hit on empty slot");

endmodule
